### sv/dft_pkg.sv
// ============================================================================
// dft_pkg: shared types and constants for the decimal field to text block
// Holds the store geometry, EBCDIC codes, sign codes, the sequencer states
// and the structs that travel between the ingest, emit and store modules.
// ============================================================================
package dft_pkg;

   // Largest digit count honored; larger counts saturate to it.
   localparam int MAX_DIGITS  = 31;
   // Digit store depth; a packed field with an even count adds one nibble.
   localparam int STORE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   // Nibble counter, saturating at its all-ones value.
   localparam int COUNT_W     = 6;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

   localparam logic [7:0] EBCDIC_ZERO  = 8'hF0;
   localparam logic [7:0] EBCDIC_MINUS = 8'h60;

   localparam logic [3:0] SIGN_NEG_B = 4'hB;
   localparam logic [3:0] SIGN_NEG_D = 4'hD;

   localparam logic MODE_PACKED = 1'b1;

   typedef enum logic {
      ING_IDLE,
      ING_LOW
   } ing_state_type;

   typedef enum logic [2:0] {
      EM_IDLE,
      EM_MINUS,
      EM_READ,
      EM_POINT0,
      EM_SEP,
      EM_DIGIT,
      EM_TAIL
   } emit_state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [3:0]        data;
   } store_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } store_rd_type;

   // Everything the emitter needs to format one field.
   typedef struct packed {
      logic               start;
      logic               neg;
      logic [COUNT_W-1:0] have;
      logic [COUNT_W-1:0] last_idx;
      logic [COUNT_W-1:0] point_idx;
      logic [7:0]         separator;
   } job_type;

endpackage

### sv/dft_req_if.sv
// ============================================================================
// dft_req_if: request channel of the decimal field to text block
// Carries one byte of a zoned or packed decimal field with its format.
// ============================================================================
interface dft_req_if;
   import dft_pkg::*;

   logic       valid;
   logic       ready;
   logic       mode;
   logic [4:0] digit_count;
   logic [4:0] fraction_digits;
   logic [7:0] separator;
   logic [7:0] source_byte;
   logic       last_byte;

   modport source (
      output valid, mode, digit_count, fraction_digits, separator,
             source_byte, last_byte,
      input  ready
   );

   modport sink (
      input  valid, mode, digit_count, fraction_digits, separator,
             source_byte, last_byte,
      output ready
   );

endinterface

### sv/dft_rsp_if.sv
// ============================================================================
// dft_rsp_if: result channel of the decimal field to text block
// Carries one EBCDIC character of the text and an end-of-text flag.
// ============================================================================
interface dft_rsp_if;
   import dft_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (
      output valid, out_char, last_char,
      input  ready
   );

   modport sink (
      input  valid, out_char, last_char,
      output ready
   );

endinterface

### sv/dft_store.sv
// ============================================================================
// dft_store: digit nibble memory
// One write port and one read port with registered read data.
// ============================================================================
module dft_store
   import dft_pkg::*;
(
   input  logic         clock,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output logic [3:0]   rd_data
);

   logic [3:0] mem [STORE_DEPTH];
   logic [3:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read data holds between reads.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dft_ingest.sv
// ============================================================================
// dft_ingest: field byte intake
// Latches the format on the first byte, writes digit nibbles to the store
// and hands a formatting job to the emitter on the last byte.
// ============================================================================
module dft_ingest
   import dft_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   dft_req_if.sink       req,
   input  logic          emit_busy,
   output store_wr_type  wr,
   output job_type       job
);

   ing_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [3:0]         low_ff, low_in;
   logic               mode_ff;
   logic [4:0]         dcount_ff;
   logic [4:0]         frac_ff;
   logic [7:0]         sep_ff;

   logic               accept;
   logic               first;
   logic               mode_cur;
   logic [4:0]         dcount_cur;
   logic [4:0]         frac_cur;
   logic [7:0]         sep_cur;
   logic [COUNT_W-1:0] count_inc;
   logic               can_store;
   logic [3:0]         sign;
   logic [COUNT_W-1:0] dig_cnt;
   logic [COUNT_W-1:0] frac_cnt;

   assign req.ready = (state_ff == ING_IDLE) && !emit_busy;
   assign accept    = req.valid && req.ready;

   // A zero count means the byte on the channel opens a new field.
   assign first      = (count_ff == '0);
   assign mode_cur   = first ? req.mode            : mode_ff;
   assign dcount_cur = first ? req.digit_count     : dcount_ff;
   assign frac_cur   = first ? req.fraction_digits : frac_ff;
   assign sep_cur    = first ? req.separator       : sep_ff;

   assign count_inc = (count_ff == COUNT_LIMIT) ? count_ff : count_ff + 1'b1;
   // Nibbles beyond the store are never read, so they are dropped.
   assign can_store = (count_ff < COUNT_W'(STORE_DEPTH));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      low_in   = low_ff;
      wr.en    = 1'b0;
      wr.addr  = count_ff[ADDR_W-1:0];
      wr.data  = low_ff;
      case (state_ff)
         ING_IDLE: begin
            if (accept) begin
               wr.en   = can_store;
               wr.data = (mode_cur == MODE_PACKED) ? req.source_byte[7:4]
                                                   : req.source_byte[3:0];
               low_in  = req.source_byte[3:0];
               if (req.last_byte) begin
                  count_in = '0;
               end else begin
                  count_in = count_inc;
                  if (mode_cur == MODE_PACKED) begin
                     state_in = ING_LOW;
                  end
               end
            end
         end
         ING_LOW: begin
            wr.en    = can_store;
            count_in = count_inc;
            state_in = ING_IDLE;
         end
         default: begin
            state_in = ING_IDLE;
         end
      endcase
   end

   // Job description, computed from the format in force for this field.
   always_comb begin
      sign = (mode_cur == MODE_PACKED) ? req.source_byte[3:0]
                                       : req.source_byte[7:4];
      dig_cnt = {1'b0, dcount_cur};
      if (dig_cnt == '0) begin
         dig_cnt = COUNT_W'(1);
      end
      if (dig_cnt > COUNT_W'(MAX_DIGITS)) begin
         dig_cnt = COUNT_W'(MAX_DIGITS);
      end
      frac_cnt = {1'b0, frac_cur};
      if (frac_cnt > dig_cnt) begin
         frac_cnt = dig_cnt;
      end
      // An even packed count carries an extra leading nibble.
      if ((mode_cur == MODE_PACKED) && !dig_cnt[0]) begin
         dig_cnt = dig_cnt + 1'b1;
      end
      job.start     = accept && req.last_byte;
      job.neg       = (sign == SIGN_NEG_B) || (sign == SIGN_NEG_D);
      job.have      = count_inc;
      job.last_idx  = dig_cnt - 1'b1;
      job.point_idx = dig_cnt - frac_cnt;
      job.separator = sep_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ING_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff <= low_in;
      if (reset) begin
         mode_ff   <= 1'b0;
         dcount_ff <= '0;
         frac_ff   <= '0;
         sep_ff    <= '0;
      end else if (accept && first) begin
         mode_ff   <= req.mode;
         dcount_ff <= req.digit_count;
         frac_ff   <= req.fraction_digits;
         sep_ff    <= req.separator;
      end
   end

endmodule

### sv/dft_emit.sv
// ============================================================================
// dft_emit: text sequencer
// Walks the stored digits one read at a time and produces the characters
// through a registered output stage.
// ============================================================================
module dft_emit
   import dft_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  job_type       job,
   output logic          busy,
   output store_rd_type  rd,
   input  logic [3:0]    rd_data,
   dft_rsp_if.source     rsp
);

   emit_state_type     state_ff, state_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               started_ff, started_in;
   job_type            job_ff;

   logic               out_valid_ff;
   logic [7:0]         out_char_ff;
   logic               out_last_ff;

   logic               slot;
   logic               load;
   logic [7:0]         ch;
   logic               lst;
   logic [7:0]         digit_char;
   logic               show;
   logic               is_end;

   assign slot = !out_valid_ff || rsp.ready;
   assign busy = (state_ff != EM_IDLE);

   assign digit_char = (idx_ff < job_ff.have) ? (EBCDIC_ZERO | {4'b0, rd_data})
                                              : EBCDIC_ZERO;
   assign show   = (digit_char != EBCDIC_ZERO) || started_ff;
   assign is_end = (idx_ff == job_ff.last_idx);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      started_in = started_ff;
      load       = 1'b0;
      ch         = EBCDIC_ZERO;
      lst        = 1'b0;
      rd.en      = 1'b0;
      rd.addr    = idx_ff[ADDR_W-1:0];
      case (state_ff)
         EM_IDLE: begin
            if (job.start) begin
               idx_in     = '0;
               started_in = 1'b0;
               state_in   = job.neg ? EM_MINUS : EM_READ;
            end
         end
         EM_MINUS: begin
            if (slot) begin
               load     = 1'b1;
               ch       = EBCDIC_MINUS;
               state_in = EM_READ;
            end
         end
         EM_READ: begin
            rd.en = 1'b1;
            if (idx_ff == job_ff.point_idx) begin
               state_in = started_ff ? EM_SEP : EM_POINT0;
            end else begin
               state_in = EM_DIGIT;
            end
         end
         EM_POINT0: begin
            if (slot) begin
               load     = 1'b1;
               state_in = EM_SEP;
            end
         end
         EM_SEP: begin
            if (slot) begin
               load       = 1'b1;
               ch         = job_ff.separator;
               started_in = 1'b1;
               state_in   = EM_DIGIT;
            end
         end
         EM_DIGIT: begin
            if (!show || slot) begin
               load = show;
               ch   = digit_char;
               lst  = is_end;
               if (show) begin
                  started_in = 1'b1;
               end
               if (is_end) begin
                  state_in = show ? EM_IDLE : EM_TAIL;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = EM_READ;
               end
            end
         end
         EM_TAIL: begin
            if (slot) begin
               load     = 1'b1;
               lst      = 1'b1;
               state_in = EM_IDLE;
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EM_IDLE;
         idx_ff       <= '0;
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         started_ff <= started_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == EM_IDLE) && job.start) begin
         job_ff <= job;
      end
      if (load) begin
         out_char_ff <= ch;
         out_last_ff <= lst;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.out_char  = out_char_ff;
   assign rsp.last_char = out_last_ff;

endmodule

### sv/decimal_field_to_text.sv
// Text is offered only after the last byte of a field is taken, starting with a minus if negative.
// One write per nibble; a zoned byte writes one nibble, a packed byte its high and then its low
// nibble (the last byte only its high one). Each digit of the text is a memory read through the
// one read port, then an output; a minus, the point (with a zero before it) and a closing zero are extra outputs.
// Requests are held off while a field is being formatted.
// Reset (synchronous, active high) clears the control state; the digit memory is not cleared.
// ============================================================================
// decimal_field_to_text: zoned or packed decimal field to EBCDIC text
// Collects the digit nibbles of a decimal field into a small memory and,
// on the byte that carries the sign, writes the value out as EBCDIC text.
// ============================================================================
module decimal_field_to_text
   import dft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dft_req_if.sink    req,
   dft_rsp_if.source  rsp
);

   // Nibble writes from the intake side and reads from the text sequencer
   // share one memory. The two sides never overlap on a field: intake stops
   // taking requests while the sequencer is busy, and the sequencer only starts
   // reading once the last nibble has been written.
   store_wr_type wr;
   store_rd_type rd;
   logic [3:0]   rd_data;

   // The job carries the sign, the number of nibbles supplied, the index of
   // the last digit, the index where the point goes and the point character.
   job_type      job;
   logic         emit_busy;

   dft_ingest u_ingest (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .emit_busy (emit_busy),
      .wr        (wr),
      .job       (job)
   );

   dft_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   // The sequencer keeps its own output register, so a finished character
   // can wait for the consumer while the next request is taken.
   dft_emit u_emit (
      .clock   (clock),
      .reset   (reset),
      .job     (job),
      .busy    (emit_busy),
      .rd      (rd),
      .rd_data (rd_data),
      .rsp     (rsp)
   );

endmodule

### sv/dft_checker.sv
// ============================================================================
// dft_checker: port-level checks for the decimal field to text block
// Watches the request and result channels and is bound to the top level.
// ============================================================================
module dft_checker
   import dft_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_char
);

   // A stalled character must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
                                  && $stable(rsp_last_char))
      else $error("result changed while stalled");

   // Formatting a field blocks further requests right after its last byte.
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> !req_ready)
      else $error("request taken while a field is being formatted");

   // Text always ends in a digit character.
   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_out_char[7:4] == EBCDIC_ZERO[7:4])
      else $error("final character is not a digit");

   // No result is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind decimal_field_to_text dft_checker u_dft_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_last_byte (req.last_byte),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_out_char  (rsp.out_char),
   .rsp_last_char (rsp.last_char)
);
